### design/dtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_pkg - shared types and constants of the double-tap wake detector
// Event codes, register indexes, slot record and configuration bundle.
// ----------------------------------------------------------------------------
package dtw_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int TIME_WIDTH  = 32;

  localparam int VALUE_WIDTH = 16;
  localparam int TS_WIDTH    = 32;
  localparam int REG_WIDTH   = 16;

  // compare widths: wide enough for both the difference and the limit
  localparam int DIST_CMP_WIDTH = (COORD_WIDTH > REG_WIDTH) ? COORD_WIDTH : REG_WIDTH;
  localparam int TIME_CMP_WIDTH = (TIME_WIDTH > REG_WIDTH) ? TIME_WIDTH : REG_WIDTH;

  localparam int IN_DATA_WIDTH  = VALUE_WIDTH + TS_WIDTH;
  localparam int OUT_DATA_WIDTH = 8;

  typedef enum logic [2:0] {
    OP_OTHER = 3'd0,
    OP_SLOT  = 3'd1,
    OP_TRACK = 3'd2,
    OP_POS_X = 3'd3,
    OP_POS_Y = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ENABLE     = 2'd0,
    REG_SCREEN_OFF = 2'd1,
    REG_INTERVAL   = 2'd2,
    REG_OFFSET     = 2'd3
  } reg_idx_t;

  localparam logic [REG_WIDTH-1:0] INTERVAL_RST = REG_WIDTH'(700);
  localparam logic [REG_WIDTH-1:0] OFFSET_RST   = REG_WIDTH'(200);

  typedef struct packed {
    logic                 enable;
    logic                 screen_off;
    logic [REG_WIDTH-1:0] tap_interval_ms;
    logic [REG_WIDTH-1:0] dist_limit;
  } cfg_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic                   x_valid;
    logic                   y_valid;
    logic [TIME_WIDTH-1:0]  time_ms;
  } slot_t;

  typedef struct packed {
    logic wake;
    logic tap_captured;
  } result_t;

endpackage

### design/dtw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_cfg - configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module dtw_cfg
  import dtw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [1:0]           addr,
  input  logic [REG_WIDTH-1:0] wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b0;
      cfg_r.screen_off      <= 1'b0;
      cfg_r.tap_interval_ms <= INTERVAL_RST;
      cfg_r.dist_limit      <= OFFSET_RST;
    end else if (we) begin
      unique case (reg_idx_t'(addr))
        REG_ENABLE:     cfg_r.enable          <= wdata[0];
        REG_SCREEN_OFF: cfg_r.screen_off      <= wdata[0];
        REG_INTERVAL:   cfg_r.tap_interval_ms <= wdata;
        REG_OFFSET:     cfg_r.dist_limit      <= wdata;
        default:        ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### design/dtw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_core - tap slot state and double-tap decision
// Holds the armed flag and both tap slots; updates them for one event a cycle while step is high.
// ----------------------------------------------------------------------------
module dtw_core
  import dtw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [2:0]             opcode,
  input  logic [COORD_WIDTH-1:0] coord,
  input  logic [TIME_WIDTH-1:0]  now,
  input  cfg_t                   cfg,
  output result_t                res
);

  logic  armed_r, armed_nxt;
  slot_t first_r, first_nxt;
  slot_t second_r, second_nxt;

  slot_t                     cur;
  logic                      use_second;
  logic [COORD_WIDTH-1:0]    dx, dy;
  logic [TIME_WIDTH-1:0]     dt;
  logic                      near;

  always_comb begin
    armed_nxt  = armed_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    res        = '0;
    use_second = first_r.x_valid && first_r.y_valid;
    cur        = use_second ? second_r : first_r;

    if (opcode == OP_POS_X) begin
      cur.x       = coord;
      cur.x_valid = 1'b1;
    end else begin
      cur.y       = coord;
      cur.y_valid = 1'b1;
    end
    if (cur.x_valid && cur.y_valid) begin
      cur.time_ms = now;
    end

    dx   = (cur.x >= first_r.x) ? (cur.x - first_r.x) : (first_r.x - cur.x);
    dy   = (cur.y >= first_r.y) ? (cur.y - first_r.y) : (first_r.y - cur.y);
    dt   = cur.time_ms - first_r.time_ms;
    near = (DIST_CMP_WIDTH'(dx) < DIST_CMP_WIDTH'(cfg.dist_limit)) &&
           (DIST_CMP_WIDTH'(dy) < DIST_CMP_WIDTH'(cfg.dist_limit)) &&
           (TIME_CMP_WIDTH'(dt) < TIME_CMP_WIDTH'(cfg.tap_interval_ms));

    if (step) begin
      priority if (!cfg.enable || !cfg.screen_off || opcode == OP_SLOT) begin
        first_nxt  = '0;
        second_nxt = '0;
      end else if (opcode == OP_TRACK) begin
        armed_nxt = 1'b1;
      end else if (armed_r && (opcode == OP_POS_X || opcode == OP_POS_Y)) begin
        if (cur.x_valid && cur.y_valid) begin
          armed_nxt        = 1'b0;
          res.tap_captured = 1'b1;
        end
        if (!use_second) begin
          first_nxt = cur;
        end else if (cur.x_valid && cur.y_valid) begin
          // both taps present: fire or slide the newer tap down
          second_nxt = '0;
          if (near) begin
            res.wake  = 1'b1;
            first_nxt = '0;
          end else begin
            first_nxt = cur;
          end
        end else begin
          second_nxt = cur;
        end
      end else begin
        // other events, or position while not armed: hold all state
        armed_nxt = armed_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      armed_r  <= armed_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

### design/double_tap_wake_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_tap_wake_detector - wake on two nearby taps from touch events
// Registered input stage, slot update logic and a registered result stage.
// ----------------------------------------------------------------------------
// The detector takes one touch event transaction per clock when not stalled,
// and returns exactly one result transaction for each, in order. An event
// travels through an input register and then a result register; the slot
// update and the distance and time compares sit in the one combinational stage
// between them, which sets the sustained rate of one event per cycle while
// out_tready stays high. The result register frees the input side while
// a result waits: the input stalls only when both registers are full and
// out_tready is low.
// A tracking-id event arms capture; position events then fill the first open
// tap slot, and a completed slot reports tap_captured. When a second tap
// completes and lies closer than the distance limit on each axis and earlier
// than tap_interval_ms after the first, wake is reported. Detection runs only
// with enable and screen_off both set; otherwise, or on a slot event, both
// slots are dropped. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module double_tap_wake_detector
  import dtw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // input events
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_DATA_WIDTH-1:0]  in_tdata,   // [15:0] value, [47:16] timestamp_ms
  input  logic [2:0]                in_tuser,   // [2:0] opcode
  // results
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DATA_WIDTH-1:0] out_tdata,  // [0] wake, [1] tap_captured, rest zero
  // configuration
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [REG_WIDTH-1:0]      cfg_wdata
);

  cfg_t    cfg;
  result_t res;

  logic                   in_valid_r;
  logic [2:0]             op_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [TS_WIDTH-1:0]    ts_r;
  logic                   out_valid_r;
  result_t                res_r;
  logic                   advance;
  logic                   fire;

  // advance the input stage whenever the result register is free or drains
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  dtw_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  dtw_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .opcode (op_r),
    .coord  (COORD_WIDTH'(value_r)),
    .now    (TIME_WIDTH'(ts_r)),
    .cfg    (cfg),
    .res    (res)
  );

  // input register: load on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_tuser;
      value_r <= in_tdata[VALUE_WIDTH-1:0];
      ts_r    <= in_tdata[IN_DATA_WIDTH-1:VALUE_WIDTH];
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_WIDTH-2){1'b0}}, res_r.tap_captured, res_r.wake};

endmodule

### design/dtw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_checker - port-level checks of the double-tap wake detector
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module dtw_checker
  import dtw_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [OUT_DATA_WIDTH-1:0] out_tdata
);

  logic last_cap_r;

  // remember whether the previous result transaction captured a tap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cap_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_cap_r <= out_tdata[1];
    end
  end

  a_wake_needs_capture: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || out_tdata[1]))
    else $error("wake without a captured tap");

  a_no_back_to_back_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && last_cap_r) |-> !out_tdata[1])
    else $error("tap captured twice without re-arming");

  a_ready_when_output_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind double_tap_wake_detector dtw_checker u_dtw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### dv/double_tap_wake_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_tap_wake_detector_test - self-checking bench for the tap detector
// Feeds touch event transactions through the stream ports and tracks slot
// state in a local detector model. Every result transaction is compared with
// the oldest predicted verdict. The run goes through several flow-control
// mixes and register settings, including the extremes of both limits.
// ----------------------------------------------------------------------------
module double_tap_wake_detector_test;
  import dtw_pkg::*;

  // event codes the block has no use for
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // cycles to let the two-stage pipe settle before a register write
  localparam int SETTLE_CYCLES = 6;
  // cycles without any transaction while work is pending
  localparam int STALL_LIMIT   = 2000;

  typedef struct {
    logic [2:0]             opc;
    logic [VALUE_WIDTH-1:0] val;
    logic [TS_WIDTH-1:0]    ts;
  } touch_ev_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_DATA_WIDTH-1:0]  in_tdata   = '0;  // [15:0] value, [47:16] timestamp_ms
  logic [2:0]                in_tuser   = '0;  // [2:0] opcode
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] out_tdata;        // [0] wake, [1] tap_captured, rest zero
  logic                      cfg_we     = 1'b0;
  logic [1:0]                cfg_addr   = '0;
  logic [REG_WIDTH-1:0]      cfg_wdata  = '0;

  // touch events waiting to be sent, and verdicts waiting for their result
  touch_ev_t ev_q[$];
  result_t   tap_verdict_q[$];

  // local copy of the detector: registers, arm flag and both tap slots
  cfg_t  tap_cfg    = '{1'b0, 1'b0, INTERVAL_RST, OFFSET_RST};
  logic  tap_armed  = 1'b0;
  slot_t tap_first  = '0;
  slot_t tap_second = '0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  logic in_fire      = 1'b0;
  logic [TS_WIDTH-1:0] t_now;

  int n_events  = 0;
  int n_taps    = 0;
  int n_wakes   = 0;
  int n_writes  = 0;
  int n_errors  = 0;
  int idle_cycles = 0;

  double_tap_wake_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Detector model: advance the slot state by one event, return its verdict
  // --------------------------------------------------------------------------
  function automatic result_t tap_detect_step(input logic [2:0] opc,
                                              input logic [VALUE_WIDTH-1:0] val,
                                              input logic [TS_WIDTH-1:0] ts);
    result_t                r;
    slot_t                  cur;
    logic                   to_second;
    logic [COORD_WIDTH-1:0] dx;
    logic [COORD_WIDTH-1:0] dy;
    logic [TIME_WIDTH-1:0]  dt;
    r = '0;
    if (!tap_cfg.enable || !tap_cfg.screen_off || opc == OP_SLOT) begin
      // inactive or a new slot: drop both taps, keep the arm flag
      tap_first  = '0;
      tap_second = '0;
    end else if (opc == OP_TRACK) begin
      tap_armed = 1'b1;
    end else if (tap_armed && (opc == OP_POS_X || opc == OP_POS_Y)) begin
      // fill the first slot that is not yet complete
      to_second = tap_first.x_valid && tap_first.y_valid;
      cur = to_second ? tap_second : tap_first;
      if (opc == OP_POS_X) begin
        cur.x       = val[COORD_WIDTH-1:0];
        cur.x_valid = 1'b1;
      end else begin
        cur.y       = val[COORD_WIDTH-1:0];
        cur.y_valid = 1'b1;
      end
      if (cur.x_valid && cur.y_valid) begin
        cur.time_ms    = ts[TIME_WIDTH-1:0];
        tap_armed      = 1'b0;
        r.tap_captured = 1'b1;
      end
      if (to_second) tap_second = cur;
      else tap_first = cur;

      if (tap_first.x_valid && tap_first.y_valid &&
          tap_second.x_valid && tap_second.y_valid) begin
        dx = (tap_second.x >= tap_first.x) ? tap_second.x - tap_first.x
                                           : tap_first.x - tap_second.x;
        dy = (tap_second.y >= tap_first.y) ? tap_second.y - tap_first.y
                                           : tap_first.y - tap_second.y;
        dt = tap_second.time_ms - tap_first.time_ms;  // wraps modulo 2^TIME_WIDTH
        if (dx < tap_cfg.dist_limit && dy < tap_cfg.dist_limit &&
            dt < tap_cfg.tap_interval_ms) begin
          r.wake     = 1'b1;
          tap_first  = '0;
          tap_second = '0;
        end else begin
          // no match: the newer tap becomes the reference
          tap_first  = tap_second;
          tap_second = '0;
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued events at the falling edge, hold until accepted
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (ev_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= ev_q[0].opc;
        in_tdata  <= {ev_q[0].ts, ev_q[0].val};
      end else begin
        // idle: scramble the payload, it must be ignored
        in_tvalid <= 1'b0;
        in_tuser  <= 3'($urandom);
        in_tdata  <= {$urandom, 16'($urandom)};
      end
    end
  end

  // throttle the result side
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted event, then check any result; a
  // watchdog ends the run when pending work stops moving
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sample
    result_t    want;
    logic [7:0] want_byte;
    logic       in_hs;
    logic       out_hs;
    in_hs  = rst_n && in_tvalid && in_tready;
    out_hs = rst_n && out_tvalid && out_tready;
    in_fire <= in_hs;

    if (in_hs) begin
      tap_verdict_q.push_back(tap_detect_step(in_tuser, in_tdata[VALUE_WIDTH-1:0],
                                              in_tdata[IN_DATA_WIDTH-1:VALUE_WIDTH]));
      void'(ev_q.pop_front());
      n_events++;
    end

    if (out_hs) begin
      if (tap_verdict_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with no event pending, expected none, got %h",
                 $time, out_tdata);
      end else begin
        want      = tap_verdict_q.pop_front();
        want_byte = {6'b0, want.tap_captured, want.wake};
        if (out_tdata !== want_byte) begin
          n_errors++;
          $display("%0t: result mismatch, expected %h (wake %b tap %b), got %h",
                   $time, want_byte, want.wake, want.tap_captured, out_tdata);
        end
        n_taps  += want.tap_captured;
        n_wakes += want.wake;
      end
    end

    if ((ev_q.size() != 0 || tap_verdict_q.size() != 0) && !in_hs && !out_hs) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles with work pending", $time, idle_cycles);
      $display("FAIL double_tap_wake_detector");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_ev(input logic [2:0] opc, input logic [VALUE_WIDTH-1:0] val,
                         input logic [TS_WIDTH-1:0] ts);
    touch_ev_t e;
    e.opc = opc;
    e.val = val;
    e.ts  = ts;
    ev_q.push_back(e);
  endtask

  // Wait until every event is sent and every result seen, then let the pipe
  // settle so the block is idle
  task automatic drain_results();
    while (ev_q.size() != 0 || tap_verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [REG_WIDTH-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_ENABLE:     tap_cfg.enable          = v[0];
      REG_SCREEN_OFF: tap_cfg.screen_off      = v[0];
      REG_INTERVAL:   tap_cfg.tap_interval_ms = v;
      REG_OFFSET:     tap_cfg.dist_limit      = v;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One tap: tracking id then both coordinates; the rough form may skip the
  // tracking id, swap the axes, rewrite an axis or slip in a stray event
  task automatic push_tap(input logic [15:0] x, input logic [15:0] y,
                          input logic [TS_WIDTH-1:0] t, input bit clean);
    bit y_first;
    y_first = !clean && ($urandom_range(0, 1) == 1);
    if (clean || $urandom_range(0, 14) != 0) push_ev(OP_TRACK, 16'($urandom), t - 32'd5);
    if (!clean && $urandom_range(0, 9) == 0)
      push_ev(3'($urandom_range(0, 7)), 16'($urandom), $urandom);
    if (!clean && $urandom_range(0, 9) == 0)
      push_ev(y_first ? OP_POS_Y : OP_POS_X, 16'($urandom), t - 32'd2);
    push_ev(y_first ? OP_POS_Y : OP_POS_X, y_first ? y : x, t - 32'd1);
    push_ev(y_first ? OP_POS_X : OP_POS_Y, y_first ? x : y, t);
  endtask

  // coordinate within about twice the current offset of base
  function automatic logic [15:0] near_coord(input logic [15:0] base);
    int          lim;
    logic [15:0] d;
    lim = 2 * int'(tap_cfg.dist_limit) + 1;
    if (lim > 65535) lim = 65535;
    d = 16'($urandom_range(0, lim));
    return ($urandom_range(0, 1) == 1) ? base + d : base - d;
  endfunction

  // Two taps, the second mostly close in space and time to the first
  task automatic push_gesture(input bit pause_mid);
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    x0 = 16'($urandom);
    y0 = 16'($urandom);
    t_now += $urandom_range(1, 5000);
    push_tap(x0, y0, t_now, 1'b0);
    // hold the sender until the first tap is fully answered
    if (pause_mid) drain_results();
    if ($urandom_range(0, 19) == 0) push_ev(OP_SLOT, 16'($urandom), t_now);
    if ($urandom_range(0, 5) == 0) begin
      x1 = 16'($urandom);
      y1 = 16'($urandom);
    end else begin
      x1 = near_coord(x0);
      y1 = near_coord(y0);
    end
    if ($urandom_range(0, 29) == 0) t_now += $urandom;
    else t_now += $urandom_range(0, 2 * int'(tap_cfg.tap_interval_ms) + 2);
    push_tap(x1, y1, t_now, 1'b0);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int n_gest,
                           input int pause_at);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int g = 0; g < n_gest; g++) begin
      push_gesture(g == pause_at);
      // occasional burst of stray events between gestures
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3))
          push_ev(3'($urandom_range(0, 7)), 16'($urandom), $urandom);
      end
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    t_now = $urandom;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: a tracking id must not arm
    push_ev(OP_TRACK, 16'hFFFF, 32'hFFFF_FFFF);
    drain_results();
    // Enabled but screen on: still inactive
    cfg_write(REG_ENABLE, 16'd1);
    push_ev(OP_TRACK, 16'h0000, 32'h0000_0000);
    drain_results();

    // Active, reset limits of 700 ms and 200 px
    cfg_write(REG_SCREEN_OFF, 16'd1);
    push_tap(16'd100, 16'd100, 32'd1000, 1'b1);
    push_ev(OP_SPARE_LO, 16'hFFFF, 32'd1100);
    push_ev(OP_SPARE_HI, 16'h5A5A, 32'd1200);
    push_tap(16'd299, 16'd1, 32'd1699, 1'b1);                // just inside: wake
    push_tap(16'd0, 16'd0, 32'hFFFF_FF00, 1'b1);
    push_tap(16'hFFFF, 16'hFFFF, 32'h0000_0100, 1'b1);       // time wraps, too far apart
    push_tap(16'hFF38, 16'hFFFF, 32'h0000_03BC, 1'b1);       // interval exactly met
    push_tap(16'hFE70, 16'hFFFF, 32'h0000_03C6, 1'b1);       // offset exactly met
    // slot event drops a half-filled tap, capture stays armed
    push_ev(OP_TRACK, 16'd0, 32'h0000_0400);
    push_ev(OP_POS_X, 16'd40, 32'h0000_0401);
    push_ev(OP_SLOT, 16'd0, 32'h0000_0402);
    push_ev(OP_POS_Y, 16'd50, 32'h0000_0403);
    drain_results();

    // Random gestures under each flow-control mix and limit setting
    cfg_write(REG_INTERVAL, 16'd700);
    cfg_write(REG_OFFSET, 16'd200);
    run_phase(0, 0, 13, -1);

    cfg_write(REG_INTERVAL, 16'hFFFF);
    cfg_write(REG_OFFSET, 16'hFFFF);
    run_phase(56, 0, 13, 4);

    cfg_write(REG_INTERVAL, 16'd0);
    cfg_write(REG_OFFSET, 16'd0);
    run_phase(0, 56, 13, -1);

    cfg_write(REG_INTERVAL, 16'($urandom_range(1, 2000)));
    cfg_write(REG_OFFSET, 16'($urandom_range(1, 600)));
    run_phase(9, 9, 8, -1);

    // screen back on, then detector disabled: everything is dropped
    cfg_write(REG_SCREEN_OFF, 16'd0);
    run_phase(9, 9, 3, -1);
    cfg_write(REG_SCREEN_OFF, 16'd1);
    cfg_write(REG_ENABLE, 16'd0);
    run_phase(9, 9, 2, -1);
    cfg_write(REG_ENABLE, 16'd1);

    // tightest nonzero limits
    cfg_write(REG_INTERVAL, 16'd1);
    cfg_write(REG_OFFSET, 16'd1);
    run_phase(9, 9, 8, -1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d touch events; %0d taps captured and %0d wake pulses checked",
             n_events, n_taps, n_wakes);
    $display("across %0d register writes and four idle/stall mixes, %0d mismatches",
             n_writes, n_errors);
    if (n_errors == 0 && tap_verdict_q.size() == 0) begin
      $display("PASS double_tap_wake_detector");
    end else begin
      $display("FAIL double_tap_wake_detector");
    end
    $finish;
  end

endmodule

### double_tap_wake_detector.f
design/dtw_pkg.sv
design/dtw_cfg.sv
design/dtw_core.sv
design/double_tap_wake_detector.sv
design/dtw_checker.sv
dv/double_tap_wake_detector_test.sv
